@@ rtl/byte_stuffing_frame_encoder_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the byte stuffing frame encoder
// Shared property shorthands used by the checker.
// ----------------------------------------------------------------------------
`ifndef BYTE_STUFFING_FRAME_ENCODER_MACROS_SVH
`define BYTE_STUFFING_FRAME_ENCODER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define BSFE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bsfe implication failed");

// Next-cycle implication, checked outside reset
`define BSFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bsfe next-cycle check failed");

`endif

@@ rtl/bsfe_pkg.sv @@
// ----------------------------------------------------------------------------
// bsfe_pkg
// Types, constants and the CRC-16/X-25 byte update for the frame encoder.
// ----------------------------------------------------------------------------
package bsfe_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CRC_W     = 16;
    localparam int unsigned CFG_IDX_W = 2;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_FLAG    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE  = 2'd2;

    localparam logic [BYTE_W-1:0] RST_FLAG    = 8'h7E;
    localparam logic [BYTE_W-1:0] RST_ADDRESS = 8'hAA;
    localparam logic [BYTE_W-1:0] RST_ESCAPE  = 8'h7D;
    localparam logic [BYTE_W-1:0] STUFF_XOR   = 8'h20;
    localparam logic [CRC_W-1:0]  CRC_INIT    = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY    = 16'h8408;

    typedef struct packed {
        logic [BYTE_W-1:0] flag_byte;
        logic [BYTE_W-1:0] address_byte;
        logic [BYTE_W-1:0] escape_byte;
    } t_cfg;

    // Classified payload item passed from front to back
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              hdr;    // frame header goes out first
        logic              stuff;  // send escape then data ^ 0x20
        logic              last;   // append CRC and closing flag
    } t_cmd;

    // Reflected CRC-16 update over one byte, LSB first
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/bsfe_fifo.sv @@
// ----------------------------------------------------------------------------
// bsfe_fifo
// Small command queue between the classifying front and the byte sequencer.
// ----------------------------------------------------------------------------
module bsfe_fifo
    import bsfe_pkg::*;
#(
    parameter int unsigned DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_wr_cmd,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_rd_cmd,
    output logic o_nonempty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full     = (r_count == CNT_FULL);
    assign o_nonempty = (r_count != '0);
    assign w_push     = i_push && !o_full;
    assign w_pop      = i_pop && o_nonempty;
    assign o_rd_cmd   = r_mem[r_rd_ptr];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/bsfe_front.sv @@
// ----------------------------------------------------------------------------
// bsfe_front
// Accepts payload bytes, tracks frame position and classifies each byte.
// ----------------------------------------------------------------------------
module bsfe_front
    import bsfe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [BYTE_W-1:0] i_s_tdata,
    input  logic              i_s_tlast,
    input  logic              i_q_full,
    output logic              o_q_push,
    output t_cmd              o_q_cmd
);

    logic r_in_frame;
    logic n_in_frame;
    logic w_xfer;

    assign o_s_tready = !i_q_full;
    assign w_xfer     = i_s_tvalid && o_s_tready;
    assign o_q_push   = w_xfer;

    // Classify the incoming byte
    always_comb begin
        o_q_cmd.data  = i_s_tdata;
        o_q_cmd.hdr   = !r_in_frame;
        o_q_cmd.stuff = (i_s_tdata == i_cfg.flag_byte) ||
                        (i_s_tdata == i_cfg.escape_byte);
        o_q_cmd.last  = i_s_tlast;
    end

    // Open a frame on its first byte, close it on the last
    always_comb begin
        n_in_frame = r_in_frame;
        if (w_xfer) begin
            n_in_frame = !i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
        end else begin
            r_in_frame <= n_in_frame;
        end
    end

endmodule

@@ rtl/bsfe_back.sv @@
// ----------------------------------------------------------------------------
// bsfe_back
// Byte sequencer: expands each command into line bytes, runs the CRC and
// drives the registered output stage.
// ----------------------------------------------------------------------------
module bsfe_back
    import bsfe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_cmd              i_cmd,
    input  logic              i_cmd_valid,
    output logic              o_pop,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [BYTE_W-1:0] o_m_tdata,
    output logic              o_m_tlast,
    output logic              o_m_tuser
);

    localparam logic [2:0] PH_FLAG  = 3'd0;
    localparam logic [2:0] PH_ADDR  = 3'd1;
    localparam logic [2:0] PH_ESC   = 3'd2;
    localparam logic [2:0] PH_SESC  = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_CRCH  = 3'd5;
    localparam logic [2:0] PH_CRCL  = 3'd6;
    localparam logic [2:0] PH_CLOSE = 3'd7;

    t_cmd              r_cmd;
    logic              r_busy;
    logic [2:0]        r_phase;
    logic [CRC_W-1:0]  r_crc;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;
    logic              r_out_end;

    logic              w_out_free;
    logic              w_adv;
    logic              w_load;
    logic [BYTE_W-1:0] w_byte;
    logic              w_feed;
    logic              w_final;
    logic              w_end;
    logic [2:0]        w_next;
    logic [2:0]        w_start;
    logic [CRC_W-1:0]  w_crc_fin;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_adv      = r_busy && w_out_free;
    assign w_crc_fin  = r_crc ^ CRC_INIT;

    // Pick the byte for the current phase and the phase after it
    always_comb begin
        w_byte  = i_cfg.flag_byte;
        w_feed  = 1'b0;
        w_final = 1'b0;
        w_end   = 1'b0;
        w_next  = r_phase;
        case (r_phase)
            PH_FLAG: begin
                w_byte = i_cfg.flag_byte;
                w_next = PH_ADDR;
            end
            PH_ADDR: begin
                w_byte = i_cfg.address_byte;
                w_feed = 1'b1;
                w_next = PH_ESC;
            end
            PH_ESC: begin
                w_byte = i_cfg.escape_byte;
                w_feed = 1'b1;
                w_next = r_cmd.stuff ? PH_SESC : PH_DATA;
            end
            PH_SESC: begin
                w_byte = i_cfg.escape_byte;
                w_feed = 1'b1;
                w_next = PH_DATA;
            end
            PH_DATA: begin
                w_byte  = r_cmd.stuff ? (r_cmd.data ^ STUFF_XOR) : r_cmd.data;
                w_feed  = 1'b1;
                w_final = !r_cmd.last;
                w_next  = PH_CRCH;
            end
            PH_CRCH: begin
                w_byte = w_crc_fin[CRC_W-1:BYTE_W];
                w_next = PH_CRCL;
            end
            PH_CRCL: begin
                w_byte = w_crc_fin[BYTE_W-1:0];
                w_next = PH_CLOSE;
            end
            PH_CLOSE: begin
                w_byte  = i_cfg.flag_byte;
                w_final = 1'b1;
                w_end   = 1'b1;
                w_next  = PH_FLAG;
            end
            default: begin
                w_next = PH_FLAG;
            end
        endcase
    end

    // Entry phase of a fresh command
    always_comb begin
        if (i_cmd.hdr) begin
            w_start = PH_FLAG;
        end else if (i_cmd.stuff) begin
            w_start = PH_SESC;
        end else begin
            w_start = PH_DATA;
        end
    end

    assign w_load = i_cmd_valid && (!r_busy || (w_adv && w_final));
    assign o_pop  = w_load;

    // Sequencer state and running CRC
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= PH_FLAG;
            r_crc   <= CRC_INIT;
        end else begin
            if (w_load) begin
                r_busy  <= 1'b1;
                r_phase <= w_start;
            end else if (w_adv && w_final) begin
                r_busy <= 1'b0;
            end else if (w_adv) begin
                r_phase <= w_next;
            end
            if (w_adv) begin
                if (w_end || r_phase == PH_FLAG) begin
                    r_crc <= CRC_INIT;
                end else if (w_feed) begin
                    r_crc <= crc_byte(r_crc, w_byte);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cmd <= i_cmd;
        end
    end

    // Output register: load a byte when it is free, drop valid on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_byte <= w_byte;
            r_out_last <= w_final;
            r_out_end  <= w_end;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_end;

endmodule

@@ rtl/byte_stuffing_frame_encoder.sv @@
// ----------------------------------------------------------------------------
// byte_stuffing_frame_encoder
// Frames payload bytes with header, byte stuffing, CRC-16/X-25 and flags.
// ----------------------------------------------------------------------------
// The encoder sends one line byte per clock when the sink is ready. A plain
// payload byte gives one line byte, a stuffed byte two; the first byte of a frame
// adds three header bytes and the last adds three trailer bytes. Throughput
// is set by the single output byte register of the sequencer; the input side
// keeps accepting bytes into a QUEUE_DEPTH-entry command queue while the
// sequencer expands earlier ones, so both sides stall independently. Each
// transfer's tlast marks the final line byte caused by one input byte, and
// tuser marks the closing flag. Registers take effect for bytes produced
// afterwards; write them while the encoder is idle.
// ----------------------------------------------------------------------------
module byte_stuffing_frame_encoder
    import bsfe_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data,
    // payload input
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [BYTE_W-1:0]    i_s_tdata,   // [7:0] data_byte
    input  logic                 i_s_tlast,   // last_byte
    // line output
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [BYTE_W-1:0]    o_m_tdata,   // [7:0] out_byte
    output logic                 o_m_tlast,   // run_last
    output logic                 o_m_tuser    // [0] frame_end
);

    t_cfg r_cfg;
    t_cmd w_push_cmd;
    t_cmd w_head_cmd;
    logic w_push;
    logic w_full;
    logic w_pop;
    logic w_nonempty;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag_byte    <= RST_FLAG;
            r_cfg.address_byte <= RST_ADDRESS;
            r_cfg.escape_byte  <= RST_ESCAPE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FLAG:    r_cfg.flag_byte    <= i_cfg_data;
                CFG_ADDRESS: r_cfg.address_byte <= i_cfg_data;
                CFG_ESCAPE:  r_cfg.escape_byte  <= i_cfg_data;
                default:     r_cfg              <= r_cfg;
            endcase
        end
    end

    bsfe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_q_full   (w_full),
        .o_q_push   (w_push),
        .o_q_cmd    (w_push_cmd)
    );

    bsfe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_wr_cmd   (w_push_cmd),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_rd_cmd   (w_head_cmd),
        .o_nonempty (w_nonempty)
    );

    bsfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (w_head_cmd),
        .i_cmd_valid (w_nonempty),
        .o_pop       (w_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

@@ rtl/bsfe_checker.sv @@
// ----------------------------------------------------------------------------
// bsfe_checker
// Port-level checks on the frame encoder, attached by bind.
// ----------------------------------------------------------------------------
`include "byte_stuffing_frame_encoder_macros.svh"

module bsfe_checker
    import bsfe_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_s_tvalid,
    input logic              o_s_tready,
    input logic              i_s_tlast,
    input logic              o_m_tvalid,
    input logic              i_m_tready,
    input logic [BYTE_W-1:0] o_m_tdata,
    input logic              o_m_tlast,
    input logic              o_m_tuser
);

    logic [7:0] r_pending;
    logic [7:0] r_open;
    logic       w_in_xfer;
    logic       w_out_run;
    logic       w_out_close;

    assign w_in_xfer   = i_s_tvalid && o_s_tready;
    assign w_out_run   = o_m_tvalid && i_m_tready && o_m_tlast;
    assign w_out_close = o_m_tvalid && i_m_tready && o_m_tuser;

    // Count input transfers whose output runs are not yet complete
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (w_in_xfer && !w_out_run) begin
            r_pending <= r_pending + 1'b1;
        end else if (w_out_run && !w_in_xfer) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    // Count frames closed on input but not yet closed on output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else if ((w_in_xfer && i_s_tlast) && !w_out_close) begin
            r_open <= r_open + 1'b1;
        end else if (w_out_close && !(w_in_xfer && i_s_tlast)) begin
            r_open <= r_open - 1'b1;
        end
    end

    `BSFE_ASSERT_NEXT(a_hold_stall, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast) && $stable(o_m_tuser))
    `BSFE_ASSERT_IMPL(a_end_is_last, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, o_m_tlast)
    `BSFE_ASSERT_IMPL(a_no_orphan_out, i_clk, i_rst_n, o_m_tvalid, r_pending != 8'd0)
    `BSFE_ASSERT_IMPL(a_close_has_frame, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, r_open != 8'd0)

endmodule

bind byte_stuffing_frame_encoder bsfe_checker u_bsfe_checker (.*);
